FILE: src/x86d_pkg.sv
// ----------------------------------------------------------------------------
// x86d_pkg
// Types and constants shared by the x86 subset decoder modules.
// ----------------------------------------------------------------------------
package x86d_pkg;

  // one-hot parse phase
  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_OPCODE = 4'b0010,
    PH_MODRM  = 4'b0100,
    PH_IMM    = 4'b1000
  } phase_e;

  localparam logic [3:0] RexHiNibble = 4'h4;
  localparam int unsigned RexRBit    = 2;
  localparam int unsigned RexBBit    = 0;

  localparam logic [7:0] OP_MOV_RI_LO = 8'hB8;
  localparam logic [7:0] OP_MOV_RI_HI = 8'hBF;
  localparam logic [7:0] OP_MOV_RM_R  = 8'h89;
  localparam logic [7:0] OP_MOV_R_RM  = 8'h8B;
  localparam logic [7:0] OP_ADD_EAX   = 8'h05;
  localparam logic [7:0] OP_SUB_EAX   = 8'h2D;
  localparam logic [7:0] OP_XOR_RM_R  = 8'h31;
  localparam logic [7:0] OP_PUSH_IMM  = 8'h68;
  localparam logic [7:0] OP_XCHG      = 8'h87;

  localparam logic [2:0] KIND_REG = 3'b001;
  localparam logic [2:0] KIND_IMM = 3'b010;
  localparam logic [2:0] KIND_MEM = 3'b100;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNSUP = 1'b1;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  prefix;
    logic [7:0]  opcode;
    logic [3:0]  reg_num;
    logic [31:0] imm;
    logic [1:0]  imm_seen;
    logic [2:0]  count;
  } state_t;

  localparam state_t StateClear = '{
    phase:    PH_FIRST,
    prefix:   8'h00,
    opcode:   8'h00,
    reg_num:  4'h0,
    imm:      32'h0,
    imm_seen: 2'd0,
    count:    3'd0
  };

  typedef struct packed {
    logic        status;
    logic [7:0]  opcode;
    logic [2:0]  kinds;
    logic [3:0]  first;
    logic [3:0]  second;
    logic [31:0] imm;
    logic [2:0]  length;
    logic [7:0]  prefix;
  } res_t;

endpackage

FILE: src/x86_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// x86_subset_instruction_decoder
// Byte-serial decoder for a small x86-64 subset with optional REX prefix.
// ----------------------------------------------------------------------------
// Takes one code byte per beat and sustains one byte per clock. A byte is
// captured in an input register, decoded against the parse state in a single
// pass, and any finished record is loaded into the output register. Only a
// stalled, full output register holds up the input side; a record then
// waits while the next byte sits in the input register.
module x86_subset_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [7:0]  opcode_o,
  output logic [2:0]  operand_kinds_o,
  output logic [3:0]  first_operand_o,
  output logic [3:0]  second_operand_o,
  output logic [31:0] immediate_o,
  output logic [2:0]  length_o,
  output logic [7:0]  prefix_o
);
  import x86d_pkg::*;

  logic       byte_vld_q;
  logic [7:0] byte_q;
  state_t     st_q;
  state_t     st_d;
  logic       out_vld_q;
  res_t       res_q;
  res_t       res_d;
  logic       emit;
  logic       adv;
  logic       fire;

  x86d_step u_step (
    .st_i   (st_q),
    .byte_i (byte_q),
    .st_o   (st_d),
    .emit_o (emit),
    .res_o  (res_d)
  );

  // output register free or draining this cycle
  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = byte_vld_q && adv;
  assign in_stall_o = byte_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      st_q       <= StateClear;
      out_vld_q  <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        byte_vld_q <= in_valid_i;
      end
      if (fire) begin
        st_q <= st_d;
      end
      if (adv) begin
        out_vld_q <= byte_vld_q && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= code_byte_i;
    end
    if (fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = res_q.status;
  assign opcode_o         = res_q.opcode;
  assign operand_kinds_o  = res_q.kinds;
  assign first_operand_o  = res_q.first;
  assign second_operand_o = res_q.second;
  assign immediate_o      = res_q.imm;
  assign length_o         = res_q.length;
  assign prefix_o         = res_q.prefix;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o != 3'd0) && (length_o != 3'd7))
    else $error("record length out of range");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_UNSUP)) |->
      (operand_kinds_o == 3'd0) && (immediate_o == 32'h0) &&
      (first_operand_o == 4'h0) && (second_operand_o == 4'h0))
    else $error("error record carries operands");

  a_imm_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_IMM) |->
      (st_q.opcode == OP_MOV_RI_LO) || (st_q.opcode == OP_ADD_EAX) ||
      (st_q.opcode == OP_SUB_EAX) || (st_q.opcode == OP_PUSH_IMM))
    else $error("immediate phase with non-immediate opcode");

  a_prefix_rex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (prefix_o != 8'h00)) |-> (prefix_o[7:4] == RexHiNibble))
    else $error("prefix field is not a REX byte");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(st_q))
    else $error("parse state moved without a decoded byte");

endmodule

FILE: src/x86d_step.sv
// ----------------------------------------------------------------------------
// x86d_step
// Next-state and result logic for one code byte of the decoder.
// ----------------------------------------------------------------------------
module x86d_step (
  input  x86d_pkg::state_t st_i,
  input  logic [7:0]       byte_i,
  output x86d_pkg::state_t st_o,
  output logic             emit_o,
  output x86d_pkg::res_t   res_o
);
  import x86d_pkg::*;

  typedef struct packed {
    state_t st;
    logic   emit;
    res_t   res;
  } step_t;

  // opcode byte handling, shared by the first-byte and after-prefix phases
  function automatic step_t take_opcode(state_t s, logic [7:0] b);
    step_t r;
    r.st   = s;
    r.emit = 1'b0;
    r.res  = '0;
    r.st.count = 3'(s.count + 3'd1);
    case (b) inside
      [OP_MOV_RI_LO:OP_MOV_RI_HI]: begin
        r.st.opcode   = OP_MOV_RI_LO;
        r.st.reg_num  = {s.prefix[RexBBit], b[2:0]};
        r.st.imm      = 32'h0;
        r.st.imm_seen = 2'd0;
        r.st.phase    = PH_IMM;
      end
      OP_ADD_EAX, OP_SUB_EAX, OP_PUSH_IMM: begin
        r.st.opcode   = b;
        r.st.reg_num  = 4'h0;
        r.st.imm      = 32'h0;
        r.st.imm_seen = 2'd0;
        r.st.phase    = PH_IMM;
      end
      OP_MOV_RM_R, OP_MOV_R_RM, OP_XOR_RM_R, OP_XCHG: begin
        r.st.opcode = b;
        r.st.phase  = PH_MODRM;
      end
      default: begin
        r.emit       = 1'b1;
        r.res.status = STATUS_UNSUP;
        r.res.opcode = b;
        r.res.length = r.st.count;
        r.res.prefix = s.prefix;
        r.st         = StateClear;
      end
    endcase
    return r;
  endfunction

  step_t      step;
  logic [3:0] reg_f;
  logic [3:0] rm_f;
  logic [31:0] imm_new;

  assign reg_f   = {st_i.prefix[RexRBit], byte_i[5:3]};
  assign rm_f    = {st_i.prefix[RexBBit], byte_i[2:0]};
  // little-endian: byte k lands at bits 8k+7:8k
  assign imm_new = st_i.imm | ({24'h0, byte_i} << {st_i.imm_seen, 3'b000});

  always_comb begin
    step.st   = st_i;
    step.emit = 1'b0;
    step.res  = '0;
    case (st_i.phase)
      PH_OPCODE: begin
        step = take_opcode(st_i, byte_i);
      end
      PH_MODRM: begin
        step.emit       = 1'b1;
        step.res.status = STATUS_OK;
        step.res.opcode = st_i.opcode;
        step.res.kinds  = ((st_i.opcode == OP_MOV_RM_R) || (st_i.opcode == OP_MOV_R_RM)) ?
                          (KIND_REG | KIND_MEM) : KIND_REG;
        if (st_i.opcode == OP_MOV_R_RM) begin
          step.res.first  = reg_f;
          step.res.second = rm_f;
        end else begin
          step.res.first  = rm_f;
          step.res.second = reg_f;
        end
        step.res.length = 3'(st_i.count + 3'd1);
        step.res.prefix = st_i.prefix;
        step.st         = StateClear;
      end
      PH_IMM: begin
        step.st.imm      = imm_new;
        step.st.imm_seen = 2'(st_i.imm_seen + 2'd1);
        step.st.count    = 3'(st_i.count + 3'd1);
        if (st_i.imm_seen == 2'd3) begin
          step.emit       = 1'b1;
          step.res.status = STATUS_OK;
          step.res.opcode = st_i.opcode;
          step.res.kinds  = (st_i.opcode == OP_PUSH_IMM) ? KIND_IMM : (KIND_REG | KIND_IMM);
          step.res.first  = st_i.reg_num;
          step.res.second = 4'h0;
          step.res.imm    = imm_new;
          step.res.length = 3'(st_i.count + 3'd1);
          step.res.prefix = st_i.prefix;
          step.st         = StateClear;
        end
      end
      default: begin
        // first byte; stray phase codes land here as well
        if (byte_i[7:4] == RexHiNibble) begin
          step.st        = StateClear;
          step.st.prefix = byte_i;
          step.st.count  = 3'd1;
          step.st.phase  = PH_OPCODE;
        end else begin
          step = take_opcode(StateClear, byte_i);
        end
      end
    endcase
  end

  assign st_o   = step.st;
  assign emit_o = step.emit;
  assign res_o  = step.res;

endmodule
